// File: sv/jads_pkg.sv
// Shared widths and configuration register indexes of the joystick axis scaler.
package jads_pkg;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int VALUE_BITS    = 16;
	localparam int OUT_MAX_BITS  = 15;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_AXIS_LOW   = 3'd0;
	localparam cfg_idx_t REG_AXIS_MID   = 3'd1;
	localparam cfg_idx_t REG_AXIS_HIGH  = 3'd2;
	localparam cfg_idx_t REG_REVERSE    = 3'd3;
	localparam cfg_idx_t REG_THRESHOLD  = 3'd4;
	localparam cfg_idx_t REG_MID_MARGIN = 3'd5;
	localparam cfg_idx_t REG_OUT_MAX    = 3'd6;
	localparam cfg_idx_t REG_OUT_MIN    = 3'd7;

endpackage

// File: sv/jads_in_if.sv
// Sample input channel: valid, ready and one raw ADC reading.
interface jads_in_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

// File: sv/jads_out_if.sv
// Result channel: valid, ready, change flag and translated axis value.
interface jads_out_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   changed;
	logic signed [jads_pkg::VALUE_BITS-1:0] axis_value;

	modport source(output valid, output changed, output axis_value, input ready);
	modport sink(input valid, input changed, input axis_value, output ready);
endinterface

// File: sv/jads_cfg_if.sv
// Configuration write channel: valid, ready, register index and write data.
interface jads_cfg_if;
	logic                              valid;
	logic                              ready;
	jads_pkg::cfg_idx_t                index;
	logic [jads_pkg::CFG_DATA_BITS-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: sv/joystick_axis_deadzone_scaler.sv
// Joystick axis dead-zone scaler: sequencer with a shared restoring divider.
//
// Usage: write calibration through cfg (always ready, one register per item,
// only while the block is idle). Feed raw samples on in_ch; each sample gives
// exactly one result on out_ch: changed = 0 and value 0 when the sample moved
// by no more than the change threshold, else changed = 1 with the scaled value.
// After a sample is accepted, an unchanged one goes from the delta state
// straight to the final state; the dead zone and a zero span pass through the
// zone and sign states, and a scaled value through the zone, multiply, divide
// and sign states, before the result is loaded and in_ch is ready again.
// The restoring divider retires one quotient bit per cycle over the
// SAMPLE_BITS + 16 bit product; in_ch is not ready while an item is in flight.
// One output register holds the result; a new sample may be taken while it
// waits. If the receiver stalls, the next result waits in the final state
// until the register is free.
// Reset: calibration takes its default values, the last sample is loaded
// with the midpoint, and no result is pending. Writing the midpoint also
// reloads the last sample.
module joystick_axis_deadzone_scaler #(
	parameter int SAMPLE_BITS = 12,
	parameter int OUT_CENTER  = 0
) (
	input logic          clk,
	input logic          arst_n,
	jads_cfg_if.sink     cfg,
	jads_in_if.sink      in_ch,
	jads_out_if.source   out_ch
);

	localparam int SB = SAMPLE_BITS;
	localparam int PW = SB + 16;
	localparam int RW = PW + 2;
	localparam int CW = $clog2(PW + 1);
	localparam int VB = jads_pkg::VALUE_BITS;
	localparam int MB = jads_pkg::OUT_MAX_BITS;
	localparam int CENTER_MAG = (OUT_CENTER < 0) ? -OUT_CENTER : OUT_CENTER;
	localparam logic CENTER_NEG = (OUT_CENTER < 0);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DELTA = 7'b0000010,
		ST_ZONE  = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_SIGN  = 7'b0100000,
		ST_CLAMP = 7'b1000000
	} state_t;

	state_t state_q;

	// calibration registers
	logic [SB-1:0]        low_q;
	logic [SB-1:0]        mid_q;
	logic [SB-1:0]        high_q;
	logic                 reverse_q;
	logic [SB-1:0]        thr_q;
	logic [SB-1:0]        margin_q;
	logic [MB-1:0]        omax_q;
	logic signed [VB-1:0] omin_q;

	// datapath registers
	logic [SB-1:0]        last_q;
	logic [SB-1:0]        smp_q;
	logic                 report_q;
	logic                 neg_q;
	logic [SB-1:0]        off_mag_q;
	logic [VB-1:0]        bnd_mag_q;
	logic [SB-1:0]        span_q;
	logic [PW-1:0]        acc_q;
	logic [SB-1:0]        rem_q;
	logic [CW-1:0]        cnt_q;
	logic signed [RW-1:0] val_q;

	// output register
	logic                 out_valid_q;
	logic                 out_changed_q;
	logic signed [VB-1:0] out_value_q;

	logic cfg_we;
	logic in_acc;
	logic out_free;

	assign cfg.ready       = 1'b1;
	assign cfg_we          = cfg.valid && cfg.ready;
	assign in_ch.ready     = (state_q == ST_IDLE);
	assign in_acc          = in_ch.valid && in_ch.ready;
	assign out_free        = !out_valid_q || out_ch.ready;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.changed    = out_changed_q;
	assign out_ch.axis_value = out_value_q;

	// change detection
	logic signed [SB:0] dlt;
	logic [SB-1:0]      dlt_mag;
	logic               moved;

	always_comb begin
		dlt     = $signed({1'b0, smp_q}) - $signed({1'b0, last_q});
		dlt_mag = dlt[SB] ? SB'(-dlt) : SB'(dlt);
		moved   = dlt_mag > thr_q;
	end

	// side selection, operand magnitudes and signs
	logic signed [SB:0]   off;
	logic signed [SB+1:0] off_x;
	logic signed [SB+1:0] marg_x;
	logic                 upper;
	logic                 lower;
	logic signed [SB:0]   span_hi;
	logic signed [SB:0]   span_lo;
	logic signed [SB:0]   span_sel;
	logic [SB-1:0]        off_mag;
	logic [SB-1:0]        span_mag;
	logic signed [VB:0]   omin_neg;
	logic [VB-1:0]        bnd_mag;

	always_comb begin
		off      = $signed({1'b0, smp_q}) - $signed({1'b0, mid_q});
		off_x    = {off[SB], off};
		marg_x   = $signed({2'b00, margin_q});
		upper    = off_x >= marg_x;
		lower    = off_x <= -marg_x;
		span_hi  = $signed({1'b0, high_q}) - $signed({1'b0, mid_q});
		span_lo  = $signed({1'b0, low_q}) - $signed({1'b0, mid_q});
		span_sel = lower ? span_lo : span_hi;
		off_mag  = off[SB] ? SB'(-off) : SB'(off);
		span_mag = span_sel[SB] ? SB'(-span_sel) : SB'(span_sel);
		omin_neg = -{omin_q[VB-1], omin_q};
		bnd_mag  = lower ? omin_neg[VB-1:0] : {1'b0, omax_q};
	end

	// one divider step
	logic [SB:0]   rem_sh;
	logic          fits;
	logic [SB-1:0] rem_nx;
	logic [PW-1:0] prod;

	always_comb begin
		rem_sh = {rem_q, acc_q[PW-1]};
		fits   = rem_sh >= {1'b0, span_q};
		rem_nx = fits ? SB'(rem_sh - {1'b0, span_q}) : SB'(rem_sh);
		prod   = off_mag_q * bnd_mag_q;
	end

	// sign application and clamping
	logic signed [RW-1:0] mag_x;
	logic signed [RW-1:0] hi_x;
	logic signed [RW-1:0] lo_x;
	logic signed [RW-1:0] clamp_a;
	logic signed [RW-1:0] clamp_b;

	always_comb begin
		mag_x   = $signed({2'b00, acc_q});
		hi_x    = $signed(RW'(omax_q));
		lo_x    = RW'(omin_q);
		clamp_a = (val_q > hi_x) ? hi_x : val_q;
		clamp_b = (clamp_a < lo_x) ? lo_x : clamp_a;
	end

	// hold calibration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q     <= '0;
			mid_q     <= SB'(2048);
			high_q    <= SB'(4095);
			reverse_q <= 1'b0;
			thr_q     <= SB'(16);
			margin_q  <= SB'(64);
			omax_q    <= MB'(32767);
			omin_q    <= VB'(-32767);
		end else if (cfg_we) begin
			case (cfg.index)
				jads_pkg::REG_AXIS_LOW:   low_q     <= cfg.data[SB-1:0];
				jads_pkg::REG_AXIS_MID:   mid_q     <= cfg.data[SB-1:0];
				jads_pkg::REG_AXIS_HIGH:  high_q    <= cfg.data[SB-1:0];
				jads_pkg::REG_REVERSE:    reverse_q <= cfg.data[0];
				jads_pkg::REG_THRESHOLD:  thr_q     <= cfg.data[SB-1:0];
				jads_pkg::REG_MID_MARGIN: margin_q  <= cfg.data[SB-1:0];
				jads_pkg::REG_OUT_MAX:    omax_q    <= cfg.data[MB-1:0];
				jads_pkg::REG_OUT_MIN:    omin_q    <= $signed(cfg.data[VB-1:0]);
				default: ;
			endcase
		end
	end

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			last_q   <= SB'(2048);
			report_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cfg_we && cfg.index == jads_pkg::REG_AXIS_MID) begin
				last_q <= cfg.data[SB-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						smp_q   <= in_ch.sample;
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					report_q <= moved;
					if (moved) begin
						last_q  <= smp_q;
						state_q <= ST_ZONE;
					end else begin
						state_q <= ST_CLAMP;
					end
				end
				ST_ZONE: begin
					if (!upper && !lower) begin
						acc_q   <= PW'(CENTER_MAG);
						neg_q   <= CENTER_NEG ^ reverse_q;
						state_q <= ST_SIGN;
					end else if (span_mag == '0) begin
						acc_q   <= PW'(bnd_mag);
						neg_q   <= lower ^ reverse_q;
						state_q <= ST_SIGN;
					end else begin
						off_mag_q <= off_mag;
						bnd_mag_q <= bnd_mag;
						span_q    <= span_mag;
						neg_q     <= off[SB] ^ lower ^ span_sel[SB] ^ reverse_q;
						state_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					acc_q   <= prod;
					rem_q   <= '0;
					cnt_q   <= CW'(PW);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_nx;
					acc_q <= {acc_q[PW-2:0], fits};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					val_q   <= neg_q ? -mag_x : mag_x;
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// load the result into the output register, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_CLAMP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLAMP && out_free) begin
			out_changed_q <= report_q;
			out_value_q   <= report_q ? clamp_b[VB-1:0] : '0;
		end
	end

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ch.ready)
		else $error("input ready while an item is in flight");

	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < span_q))
		else $error("divider remainder not below divisor");

	a_mid_reloads_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg.index == jads_pkg::REG_AXIS_MID)
		|=> (last_q == $past(cfg.data[SB-1:0])))
		else $error("midpoint write did not reload last sample");

	a_result_from_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_CLAMP))
		else $error("result appeared outside the final state");

	a_quiet_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_changed_q) |-> (out_value_q == '0))
		else $error("unchanged result carries a nonzero value");
`endif

endmodule
